// File: rtl/kuf_pkg.sv
// Shared types and constants for the union-find edge stage.
package kuf_pkg;

  localparam int unsigned MAX_NODES = 2048;
  localparam int unsigned NodeW     = $clog2(MAX_NODES);
  localparam int unsigned RankW     = 4;
  localparam int unsigned WeightW   = 17;
  localparam int unsigned SumW      = 32;

  localparam logic [NodeW-1:0] NodeLimit = NodeW'(MAX_NODES - 1);
  localparam logic [RankW-1:0] RankMax   = '1;

  // Configuration register indexes
  localparam logic [1:0] CfgPlants    = 2'd0;
  localparam logic [1:0] CfgConsumers = 2'd1;

  // Item classes decided by the front
  typedef enum logic [1:0] {
    KindStart,
    KindBad,
    KindEdge
  } kind_e;

  // Queue entry; for a start item node_a carries the plant count and
  // node_b the clamped node total
  typedef struct packed {
    kind_e              kind;
    logic [NodeW-1:0]   node_a;
    logic [NodeW-1:0]   node_b;
    logic [WeightW-1:0] weight;
  } job_t;

  // One forest entry: rank and parent
  typedef struct packed {
    logic [RankW-1:0] rank;
    logic [NodeW-1:0] parent;
  } uf_entry_t;

endpackage

// File: rtl/kuf_front.sv
// Front end: configuration registers, input transfer and item classification.
module kuf_front import kuf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [NodeW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [NodeW-1:0]   node_a_i,
  input  logic [NodeW-1:0]   node_b_i,
  input  logic [WeightW-1:0] edge_weight_i,
  output logic               push_o,
  output job_t               job_o,
  input  logic               full_i
);

  logic [NodeW-1:0] plants_q, consumers_q, total_q, total_d;
  logic [NodeW:0]   sum_w;
  logic             bad_w;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full_i;
  assign push_o      = in_valid_i && !full_i;

  // clamp node total to the table size
  assign sum_w   = {1'b0, plants_q} + {1'b0, consumers_q};
  assign total_d = (sum_w > {1'b0, NodeLimit}) ? NodeLimit : sum_w[NodeW-1:0];

  // endpoint range check against the forest the item will see
  assign bad_w = (node_a_i == '0) || (node_b_i == '0) ||
                 (node_a_i > total_q) || (node_b_i > total_q);

  always_comb begin
    job_o.weight = edge_weight_i;
    if (!mode_i) begin
      job_o.kind   = KindStart;
      job_o.node_a = plants_q;
      job_o.node_b = total_d;
    end else begin
      job_o.kind   = bad_w ? KindBad : KindEdge;
      job_o.node_a = node_a_i;
      job_o.node_b = node_b_i;
    end
  end

  // config registers and the node total seen by later items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plants_q    <= NodeW'(1);
      consumers_q <= '0;
      total_q     <= NodeW'(1);
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgPlants:    plants_q    <= cfg_data_i;
          CfgConsumers: consumers_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (push_o && !mode_i) total_q <= total_d;
    end
  end

endmodule

// File: rtl/kuf_queue.sv
// Two-entry queue between front and back.
module kuf_queue import kuf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t       slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign job_o   = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= job_i;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i)  rptr_q <= !rptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/kuf_back.sv
// Back end: forest memory, find with path compression, union and result register.
module kuf_back import kuf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  job_t             job_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             edge_accepted_o,
  output logic             bad_node_o,
  output logic [SumW-1:0]  tree_total_o,
  output logic [NodeW-1:0] edges_taken_o,
  output logic             tree_complete_o
);

  typedef enum logic [3:0] {
    StIdle, StSweep, StFaIssue, StFaWalk, StCaWalk, StFbIssue, StFbWalk,
    StCbWalk, StUnion, StUnion2, StEmit
  } state_e;

  localparam int unsigned AddrW = $clog2(MAX_NODES);

  uf_entry_t mem [MAX_NODES];
  uf_entry_t rd_q, wr_data;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic             wr_en;

  state_e             state_q;
  job_t               job_q;
  logic [NodeW-1:0]   plants_q, total_q, taken_q, target_w;
  logic [SumW-1:0]    sum_q;
  logic [NodeW:0]     idx_q;
  logic [NodeW-1:0]   cur_q, ra_q, rb_q;
  logic [RankW-1:0]   rka_q, rkb_q;
  logic               acc_q, bad_q;
  logic [SumW:0]      sum_ext;
  logic               emit_w;

  assign target_w = (total_q == '0) ? '0 : total_q - NodeW'(1);
  assign sum_ext  = {1'b0, sum_q} + (SumW+1)'(job_q.weight);
  assign pop_o    = (state_q == StIdle) && valid_i;
  assign emit_w   = (state_q == StEmit) && (!out_valid_o || out_ready_i);

  // forest memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  // memory port control
  always_comb begin
    rd_addr = cur_q[AddrW-1:0];
    wr_en   = 1'b0;
    wr_addr = cur_q[AddrW-1:0];
    wr_data = rd_q;
    case (state_q)
      StSweep: begin
        wr_en   = idx_q <= {1'b0, total_q};
        wr_addr = idx_q[AddrW-1:0];
        // node 1 starts with rank 1 whether or not it is a plant
        wr_data.rank = (idx_q[NodeW-1:0] == NodeW'(1)) ? RankW'(1) : '0;
        if (idx_q[NodeW-1:0] <= plants_q) begin
          wr_data.parent = NodeW'(1);
        end else begin
          wr_data.parent = idx_q[NodeW-1:0];
        end
      end
      StFaIssue: rd_addr = job_q.node_a[AddrW-1:0];
      StFbIssue: rd_addr = job_q.node_b[AddrW-1:0];
      StFaWalk, StFbWalk: begin
        if (rd_q.parent == cur_q)
          rd_addr = (state_q == StFaWalk) ? job_q.node_a[AddrW-1:0]
                                          : job_q.node_b[AddrW-1:0];
        else
          rd_addr = rd_q.parent[AddrW-1:0];
      end
      StCaWalk, StCbWalk: begin
        // point the visited node straight at its root
        wr_en          = 1'b1;
        wr_data.parent = (state_q == StCaWalk) ? ra_q : rb_q;
        rd_addr        = rd_q.parent[AddrW-1:0];
      end
      StUnion: begin
        wr_en = ra_q != rb_q;
        if (rka_q < rkb_q) begin
          wr_addr = ra_q[AddrW-1:0];
          wr_data = '{rank: rka_q, parent: rb_q};
        end else begin
          wr_addr = rb_q[AddrW-1:0];
          wr_data = '{rank: rkb_q, parent: ra_q};
        end
      end
      StUnion2: begin
        wr_en   = 1'b1;
        wr_addr = ra_q[AddrW-1:0];
        wr_data = '{rank: (rka_q == RankMax) ? rka_q : rka_q + RankW'(1), parent: ra_q};
      end
      default: ;
    endcase
  end

  // sequencer, forest totals and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      job_q           <= '0;
      plants_q        <= NodeW'(1);
      total_q         <= NodeW'(1);
      taken_q         <= '0;
      sum_q           <= '0;
      idx_q           <= '0;
      cur_q           <= '0;
      ra_q            <= '0;
      rb_q            <= '0;
      rka_q           <= '0;
      rkb_q           <= '0;
      acc_q           <= 1'b0;
      bad_q           <= 1'b0;
      out_valid_o     <= 1'b0;
      edge_accepted_o <= 1'b0;
      bad_node_o      <= 1'b0;
      tree_total_o    <= '0;
      edges_taken_o   <= '0;
      tree_complete_o <= 1'b0;
    end else begin
      if (emit_w) out_valid_o <= 1'b1;
      else if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        StIdle: begin
          if (valid_i) begin
            job_q <= job_i;
            acc_q <= 1'b0;
            bad_q <= 1'b0;
            case (job_i.kind)
              KindStart: begin
                plants_q <= job_i.node_a;
                total_q  <= job_i.node_b;
                sum_q    <= '0;
                taken_q  <= '0;
                idx_q    <= (NodeW+1)'(1);
                state_q  <= StSweep;
              end
              KindBad: begin
                bad_q   <= 1'b1;
                state_q <= StEmit;
              end
              default: begin
                state_q <= (taken_q < target_w) ? StFaIssue : StEmit;
              end
            endcase
          end
        end
        StSweep: begin
          idx_q <= idx_q + (NodeW+1)'(1);
          if (idx_q > {1'b0, total_q}) state_q <= StEmit;
        end
        StFaIssue: begin
          cur_q   <= job_q.node_a;
          state_q <= StFaWalk;
        end
        StFaWalk: begin
          if (rd_q.parent == cur_q) begin
            ra_q    <= cur_q;
            rka_q   <= rd_q.rank;
            cur_q   <= job_q.node_a;
            state_q <= (cur_q == job_q.node_a) ? StFbIssue : StCaWalk;
          end else begin
            cur_q <= rd_q.parent;
          end
        end
        StCaWalk: begin
          cur_q <= rd_q.parent;
          if (rd_q.parent == ra_q) state_q <= StFbIssue;
        end
        StFbIssue: begin
          cur_q   <= job_q.node_b;
          state_q <= StFbWalk;
        end
        StFbWalk: begin
          if (rd_q.parent == cur_q) begin
            rb_q    <= cur_q;
            rkb_q   <= rd_q.rank;
            cur_q   <= job_q.node_b;
            state_q <= (cur_q == job_q.node_b) ? StUnion : StCbWalk;
          end else begin
            cur_q <= rd_q.parent;
          end
        end
        StCbWalk: begin
          cur_q <= rd_q.parent;
          if (rd_q.parent == rb_q) state_q <= StUnion;
        end
        StUnion: begin
          if (ra_q == rb_q) begin
            state_q <= StEmit;
          end else begin
            acc_q   <= 1'b1;
            sum_q   <= sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
            taken_q <= taken_q + NodeW'(1);
            state_q <= (rka_q == rkb_q) ? StUnion2 : StEmit;
          end
        end
        StUnion2: state_q <= StEmit;
        StEmit: begin
          if (emit_w) begin
            edge_accepted_o <= acc_q;
            bad_node_o      <= bad_q;
            tree_total_o    <= sum_q;
            edges_taken_o   <= taken_q;
            tree_complete_o <= taken_q >= target_w;
            state_q         <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// File: rtl/kruskal_union_find_edge_stage.sv
// Top level of the union-find edge stage of a spanning-tree builder.
//
//  channel | direction | handshake            | payload
//  cfg     | in        | cfg_valid_i/ready_o  | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/ready_o   | mode, node_a, node_b, edge_weight
//  out     | out       | out_valid_o/ready_i  | edge_accepted .. tree_complete
//
// An edge runs a find with path compression on node_a, then on node_b, then
// up to two union writes; the forest memory has one write and one read port.
// A start item sweeps entries 1..node total, one per cycle (up to 2047).
// After reset no sweep is needed (one node, tree complete at once).
// A two-entry queue lets the front keep taking items while the back works;
// the result register holds while out_ready_i is low.
module kruskal_union_find_edge_stage import kuf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [NodeW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [NodeW-1:0]   node_a_i,
  input  logic [NodeW-1:0]   node_b_i,
  input  logic [WeightW-1:0] edge_weight_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               edge_accepted_o,
  output logic               bad_node_o,
  output logic [SumW-1:0]    tree_total_o,
  output logic [NodeW-1:0]   edges_taken_o,
  output logic               tree_complete_o
);

  logic push, full, pop, qvalid;
  job_t fjob, qjob;

  kuf_front u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .mode_i, .node_a_i, .node_b_i, .edge_weight_i,
    .push_o(push), .job_o(fjob), .full_i(full)
  );

  kuf_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(fjob), .full_o(full),
    .pop_i(pop), .valid_o(qvalid), .job_o(qjob)
  );

  kuf_back u_back (
    .clk_i, .rst_ni, .valid_i(qvalid), .job_i(qjob), .pop_o(pop),
    .out_valid_o, .out_ready_i, .edge_accepted_o, .bad_node_o,
    .tree_total_o, .edges_taken_o, .tree_complete_o
  );

  // accepted edge is never a bad one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && edge_accepted_o |-> !bad_node_o)
    else $error("accepted edge flagged bad");

  // accepted edge implies a nonzero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && edge_accepted_o |-> edges_taken_o != '0)
    else $error("accepted edge with zero count");

  // no queue pop while the queue is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> qvalid)
    else $error("pop from empty queue");

endmodule
